[hw/rtl/sequence_reorder_buffer_core_assert.svh]
// Assertion macros shared by the reorder buffer modules.
`ifndef SEQUENCE_REORDER_BUFFER_CORE_ASSERT_SVH
`define SEQUENCE_REORDER_BUFFER_CORE_ASSERT_SVH

// Concurrent check, disabled while in reset.
`define SRB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication check, disabled while in reset.
`define SRB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/srb_pkg.sv]
`default_nettype none
package srb_pkg;
    localparam int NUM_PEERS   = 4;
    localparam int WINDOW      = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int PIDX_W  = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SADDR_W = PIDX_W + SLOT_W;
    localparam int QADDR_W = PIDX_W + QIDX_W;

    localparam logic [3:0] ST_IN_ORDER = 4'd0;
    localparam logic [3:0] ST_STASHED  = 4'd1;
    localparam logic [3:0] ST_STALE    = 4'd2;
    localparam logic [3:0] ST_OUT_WIN  = 4'd3;
    localparam logic [3:0] ST_Q_FULL   = 4'd4;
    localparam logic [3:0] ST_POPPED   = 4'd5;
    localparam logic [3:0] ST_EMPTY    = 4'd6;
    localparam logic [3:0] ST_FUTURE   = 4'd7;
    localparam logic [3:0] ST_UNKNOWN  = 4'd8;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  peer;
        logic [31:0] seq_count;
        logic [15:0] item_generation;
        logic        has_state;
        logic [31:0] time_seconds;
        logic [59:0] time_atto;
        logic [31:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [4:0]  released_count;
        logic [4:0]  discarded_count;
        logic [31:0] out_seq;
        logic [15:0] out_generation;
        logic        out_has_state;
        logic [31:0] out_seconds;
        logic [59:0] out_atto;
        logic [31:0] out_payload;
        logic [31:0] latest_seconds;
        logic [59:0] latest_atto;
    } out_item_t;

    // record as stored in stash and queue
    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] gen;
        logic        st;
        logic [31:0] sec;
        logic [59:0] atto;
        logic [31:0] pay;
    } rec_t;

    function automatic logic is_later(logic [31:0] s, logic [59:0] a,
                                      logic [31:0] ls, logic [59:0] la);
        return (s > ls) || ((s == ls) && (a > la));
    endfunction
endpackage
`default_nettype wire

[hw/rtl/srb_front.sv]
`default_nettype none
// Input side: takes items, checks the peer, and queues them for the engine.
module srb_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire srb_pkg::in_item_t in_item,
    output logic                 cmd_valid,
    input  wire logic            cmd_take,
    output srb_pkg::in_item_t    cmd_item,
    output logic                 cmd_bad_peer
);
    import srb_pkg::*;

    localparam int FD = 2;

    in_item_t fifo_reg [FD];
    logic     bad_reg  [FD];
    logic     wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic     do_push, do_pop, bad_in;

    assign full     = (cnt_reg == 2'(FD));
    assign do_push  = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign do_pop   = cmd_take && cmd_valid;
    assign bad_in   = ({30'd0, in_item.peer} >= 32'(NUM_PEERS));
    assign cmd_item = fifo_reg[rp_reg];
    assign cmd_bad_peer = bad_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= ~wp_reg;
            if (do_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wp_reg] <= in_item;
            bad_reg[wp_reg]  <= bad_in;
        end
    end

`include "sequence_reorder_buffer_core_assert.svh"
    `SRB_ASSERT(a_cnt_range, cnt_reg <= 2'(FD), "front queue overfilled")
    `SRB_ASSERT_IMP(a_take_valid, cmd_take, cmd_valid, "engine took from empty queue")
    `SRB_ASSERT_IMP(a_full_hold, full && !do_pop, ##1 full, "full dropped without take")
endmodule
`default_nettype wire

[hw/rtl/srb_engine.sv]
`default_nettype none
// Back side: per-peer stash and queue, drain and pop walks, one result register.
module srb_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              cmd_valid,
    output logic                   cmd_take,
    input  wire srb_pkg::in_item_t cmd_item,
    input  wire logic              cmd_bad_peer,
    output logic                   empty,
    input  wire logic              pop,
    output srb_pkg::out_item_t     out_item
);
    import srb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_D1_RD, S_D1_CHK, S_CLASSIFY, S_D2_RD, S_D2_CHK,
        S_P_RD, S_P_CHK, S_DONE
    } state_t;

    state_t      state_reg;
    logic [15:0] cur_gen_reg;
    logic [31:0] exp_reg   [NUM_PEERS];
    logic        known_reg [NUM_PEERS];
    logic [QIDX_W-1:0] head_reg [NUM_PEERS];
    logic [QCNT_W-1:0] qcnt_reg [NUM_PEERS];
    logic [31:0] lsec_reg  [NUM_PEERS];
    logic [59:0] latto_reg [NUM_PEERS];
    logic [NUM_PEERS*WINDOW-1:0] sval_reg;

    rec_t stash_mem [NUM_PEERS*WINDOW];
    rec_t queue_mem [NUM_PEERS*QUEUE_DEPTH];
    rec_t srd_reg, qrd_reg;

    in_item_t    it_reg;
    logic [PIDX_W-1:0] p_reg;
    logic [4:0]  rel_reg, dis_reg;
    logic [3:0]  st_reg;
    rec_t        outrec_reg;
    logic        have_reg;
    out_item_t   res_reg;

    logic [SADDR_W-1:0] exp_slot;
    logic [QADDR_W-1:0] tail_addr, head_addr;
    logic [31:0] diff;
    logic        qfull;
    logic        res_load;
    rec_t        new_rec;

    assign exp_slot  = {p_reg, exp_reg[p_reg][SLOT_W-1:0]};
    assign tail_addr = {p_reg, QIDX_W'(head_reg[p_reg] + QIDX_W'(qcnt_reg[p_reg]))};
    assign head_addr = {p_reg, head_reg[p_reg]};
    assign diff      = it_reg.seq_count - exp_reg[p_reg];
    assign qfull     = (qcnt_reg[p_reg] == QCNT_W'(QUEUE_DEPTH));
    assign new_rec   = '{seq: it_reg.seq_count, gen: it_reg.item_generation,
                         st: it_reg.has_state, sec: it_reg.time_seconds,
                         atto: it_reg.time_atto, pay: it_reg.payload};

    // finished item moves into the result register once it is free or being read
    assign res_load = (state_reg == S_DONE) && (!have_reg || pop);

    assign cmd_take = (state_reg == S_IDLE) && cmd_valid;
    assign empty    = !have_reg;
    assign out_item = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_gen_reg <= 16'd1;
            sval_reg    <= '0;
            have_reg    <= 1'b0;
            for (int i = 0; i < NUM_PEERS; i++)
            begin
                exp_reg[i]   <= '0;
                known_reg[i] <= 1'b0;
                head_reg[i]  <= '0;
                qcnt_reg[i]  <= '0;
                lsec_reg[i]  <= '0;
                latto_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                cur_gen_reg <= cfg_data;
            if (res_load)
                have_reg <= 1'b1;
            else if (pop && have_reg)
                have_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        it_reg  <= cmd_item;
                        p_reg   <= PIDX_W'(cmd_item.peer);
                        rel_reg <= '0;
                        dis_reg <= '0;
                        outrec_reg <= '0;
                        if (cmd_bad_peer || (cmd_item.req_type == REQ_POP
                                && !known_reg[PIDX_W'(cmd_item.peer)]))
                        begin
                            st_reg    <= ST_UNKNOWN;
                            state_reg <= S_DONE;
                        end
                        else if (cmd_item.req_type == REQ_POP)
                        begin
                            st_reg    <= ST_EMPTY;
                            state_reg <= S_P_RD;
                        end
                        else
                        begin
                            known_reg[PIDX_W'(cmd_item.peer)] <= 1'b1;
                            state_reg <= S_D1_RD;
                        end
                    end
                end
                S_D1_RD, S_D2_RD:
                begin
                    srd_reg <= stash_mem[exp_slot];
                    if (qfull || !sval_reg[exp_slot])
                        state_reg <= (state_reg == S_D1_RD) ? S_CLASSIFY : S_DONE;
                    else
                        state_reg <= (state_reg == S_D1_RD) ? S_D1_CHK : S_D2_CHK;
                end
                S_D1_CHK, S_D2_CHK:
                begin
                    if (is_later(srd_reg.sec, srd_reg.atto, lsec_reg[p_reg],
                                 latto_reg[p_reg]))
                    begin
                        lsec_reg[p_reg]  <= srd_reg.sec;
                        latto_reg[p_reg] <= srd_reg.atto;
                    end
                    sval_reg[exp_slot] <= 1'b0;
                    exp_reg[p_reg]     <= exp_reg[p_reg] + 32'd1;
                    qcnt_reg[p_reg]    <= qcnt_reg[p_reg] + QCNT_W'(1);
                    if (rel_reg != 5'd31)
                        rel_reg <= rel_reg + 5'd1;
                    state_reg <= (state_reg == S_D1_CHK) ? S_D1_RD : S_D2_RD;
                end
                S_CLASSIFY:
                begin
                    state_reg <= S_D2_RD;
                    priority if (diff == 32'd0)
                    begin
                        if (qfull)
                            st_reg <= ST_Q_FULL;
                        else
                        begin
                            st_reg <= ST_IN_ORDER;
                            if (it_reg.has_state && is_later(it_reg.time_seconds,
                                    it_reg.time_atto, lsec_reg[p_reg], latto_reg[p_reg]))
                            begin
                                lsec_reg[p_reg]  <= it_reg.time_seconds;
                                latto_reg[p_reg] <= it_reg.time_atto;
                            end
                            exp_reg[p_reg]  <= exp_reg[p_reg] + 32'd1;
                            qcnt_reg[p_reg] <= qcnt_reg[p_reg] + QCNT_W'(1);
                            if (rel_reg != 5'd31)
                                rel_reg <= rel_reg + 5'd1;
                        end
                    end
                    else if (it_reg.seq_count < exp_reg[p_reg])
                        st_reg <= ST_STALE;
                    else if (diff < 32'(WINDOW))
                    begin
                        st_reg <= ST_STASHED;
                        sval_reg[{p_reg, it_reg.seq_count[SLOT_W-1:0]}] <= 1'b1;
                    end
                    else
                        st_reg <= ST_OUT_WIN;
                end
                S_P_RD:
                begin
                    qrd_reg <= queue_mem[head_addr];
                    state_reg <= (qcnt_reg[p_reg] == '0) ? S_DONE : S_P_CHK;
                end
                S_P_CHK:
                begin
                    if (qrd_reg.gen > cur_gen_reg)
                    begin
                        st_reg    <= ST_FUTURE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        head_reg[p_reg] <= head_reg[p_reg] + QIDX_W'(1);
                        qcnt_reg[p_reg] <= qcnt_reg[p_reg] - QCNT_W'(1);
                        if (qrd_reg.gen == cur_gen_reg)
                        begin
                            st_reg     <= ST_POPPED;
                            outrec_reg <= qrd_reg;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            if (dis_reg != 5'd31)
                                dis_reg <= dis_reg + 5'd1;
                            state_reg <= S_P_RD;
                        end
                    end
                end
                S_DONE:
                begin
                    if (res_load)
                    begin
                        res_reg.status          <= st_reg;
                        res_reg.released_count  <= rel_reg;
                        res_reg.discarded_count <= dis_reg;
                        res_reg.out_seq         <= outrec_reg.seq;
                        res_reg.out_generation  <= outrec_reg.gen;
                        res_reg.out_has_state   <= outrec_reg.st;
                        res_reg.out_seconds     <= outrec_reg.sec;
                        res_reg.out_atto        <= outrec_reg.atto;
                        res_reg.out_payload     <= outrec_reg.pay;
                        if (st_reg == ST_UNKNOWN)
                        begin
                            res_reg.latest_seconds <= '0;
                            res_reg.latest_atto    <= '0;
                        end
                        else
                        begin
                            res_reg.latest_seconds <= lsec_reg[p_reg];
                            res_reg.latest_atto    <= latto_reg[p_reg];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Stash and queue storage: one write port each.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLASSIFY && diff != 32'd0
                && !(it_reg.seq_count < exp_reg[p_reg]) && diff < 32'(WINDOW))
            stash_mem[{p_reg, it_reg.seq_count[SLOT_W-1:0]}] <= new_rec;
        if (state_reg == S_D1_CHK || state_reg == S_D2_CHK)
            queue_mem[tail_addr] <= '{seq: exp_reg[p_reg], gen: srd_reg.gen,
                st: srd_reg.st, sec: srd_reg.sec, atto: srd_reg.atto, pay: srd_reg.pay};
        else if (state_reg == S_CLASSIFY && diff == 32'd0 && !qfull)
            queue_mem[tail_addr] <= new_rec;
    end

`include "sequence_reorder_buffer_core_assert.svh"
    `SRB_ASSERT_IMP(a_done_hold, state_reg == S_DONE && have_reg && !pop,
        ##1 (state_reg == S_DONE), "result overwritten")
    `SRB_ASSERT_IMP(a_chk_room, state_reg == S_D1_CHK || state_reg == S_D2_CHK,
        !qfull, "drain into full queue")
    `SRB_ASSERT_IMP(a_pop_nonempty, state_reg == S_P_CHK, qcnt_reg[p_reg] != '0,
        "pop check on empty queue")
endmodule
`default_nettype wire

[hw/rtl/sequence_reorder_buffer_core.sv]
`default_nettype none
// Sequence reorder buffer: per-peer in-order delivery of numbered records.
// Items enter through a push/full queue interface (arrival or pop request)
// and one result per item leaves through an empty/pop interface. A two-entry
// front queue decouples input from the engine, which walks the stash and the
// ready queue one entry at a time (read, then check). An arrival drains the
// records that are in order before and after it is classified; a pop reads
// and discards older-generation entries until it finds a current-generation
// entry, a newer one or an empty queue. The result register holds one item;
// while it is unread the engine goes on with the next item and holds that
// result in its last state until the register frees. The generation register
// (cfg_we/cfg_data) resets to 1; the user must write it only while the block
// is idle, and the block itself does not enforce this. No clearing pass is
// needed after reset.
module sequence_reorder_buffer_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire srb_pkg::in_item_t   in_item,
    output logic                     empty,
    input  wire logic                pop,
    output srb_pkg::out_item_t       out_item,
    input  wire logic                cfg_we,
    input  wire logic [15:0]         cfg_data
);
    import srb_pkg::*;

    logic     cmd_valid, cmd_take, cmd_bad_peer;
    in_item_t cmd_item;

    srb_front u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .cmd_valid, .cmd_take, .cmd_item, .cmd_bad_peer
    );

    srb_engine u_engine (
        .clk, .rst_n, .cfg_we, .cfg_data,
        .cmd_valid, .cmd_take, .cmd_item, .cmd_bad_peer,
        .empty, .pop, .out_item
    );
endmodule
`default_nettype wire
